// ----- hdl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key/value cache
// Field widths, operation codes and the word types passed along the cell row.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CFG_W = 5;

    // storage depth default
    localparam int MAX_ENTRIES_DEF = 16;

    // capacity register reset value
    localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

    // operation codes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // one stored entry, also the word handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic             go;
        logic             hit;
        logic             set;
        logic [KEY_W-1:0] key;
    } t_cmd;

endpackage

// ----- hdl/lkvc_cell.sv -----
// ----------------------------------------------------------------------------
// lkvc_cell: one position of the recency stack
// Holds one entry; position in the row is its recency rank (0 = most recent).
// Compares its key, passes the hit flag upward and takes its upper neighbor's
// entry when the stack shifts down.
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int IDX   = 0,
    parameter int CAP_W = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  lkvc_pkg::t_cmd             i_cmd,
    input  logic [CAP_W-1:0]           i_cap,
    input  lkvc_pkg::t_entry           i_up,
    output lkvc_pkg::t_entry           o_entry,
    input  logic                       i_hit_below,
    output logic                       o_hit_below,
    output logic [lkvc_pkg::VAL_W-1:0] o_hit_value,
    output logic                       o_tail_valid,
    output logic [lkvc_pkg::KEY_W-1:0] o_tail_key
);
    import lkvc_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             match;
    logic             shift;
    logic             in_cap;
    logic             is_tail;

    // key compare and hit flag toward the head
    assign match       = r_valid && (r_key == i_cmd.key);
    assign o_hit_below = match | i_hit_below;
    assign o_hit_value = match ? r_value : '0;

    // position against the active capacity
    assign in_cap  = CAP_W'(IDX) < i_cap;
    assign is_tail = CAP_W'(IDX + 1) == i_cap;

    assign o_tail_valid = r_valid && is_tail;
    assign o_tail_key   = o_tail_valid ? r_key : '0;

    // shift on a miss set, or at and above the hit position on a hit
    assign shift = i_cmd.go && (i_cmd.hit ? o_hit_below : i_cmd.set);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (shift) begin
            r_valid <= i_up.valid && in_cap;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key   <= i_up.key;
            r_value <= i_up.value;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

endmodule

// ----- hdl/lru_key_value_cache_core.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key/value cache, lru replacement
// Recency stack built from a row of cells; the head holds the newest entry.
// ----------------------------------------------------------------------------
// Usage:
//   command channel: an operation word (i_mode, i_key, i_value) is taken at a
//   rising edge with start high and busy low. mode get looks up the key,
//   mode set updates or inserts it, evicting the oldest entry when full.
//   result channel: o_done is high for exactly one cycle with o_found,
//   o_read_value, o_evicted and o_evicted_key valid in that cycle. the
//   receiver cannot stall; the result registers hold until the next word's result.
//   timing: the accepting edge loads the registered command stage ahead of
//   the cell row; the row compares all keys and shifts the stack at the
//   next edge, which also raises o_done. busy is high for one cycle, and no
//   new word is taken while busy is high.
//   config channel: i_cfg_valid/o_cfg_ready write the active entry count
//   (0 acts as 1, above MAX_ENTRIES acts as MAX_ENTRIES); every write empties
//   the cache. o_cfg_ready is low while a word is at work.
//   reset: cache empty, active entry count 16, no result pending.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_mode,
    input  logic [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [lkvc_pkg::VAL_W-1:0] i_value,
    output logic                       o_done,
    output logic                       o_found,
    output logic [lkvc_pkg::VAL_W-1:0] o_read_value,
    output logic                       o_evicted,
    output logic [lkvc_pkg::KEY_W-1:0] o_evicted_key,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0] i_cfg_data
);
    import lkvc_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W   = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;

    logic             r_busy;
    logic             r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CFG_W-1:0] r_active;
    logic             r_done;
    logic             r_found;
    logic [VAL_W-1:0] r_read_value;
    logic             r_evicted;
    logic [KEY_W-1:0] r_evicted_key;

    logic             cfg_write;
    logic             accept;
    logic [CAP_W-1:0] active_ext;
    logic [CAP_W-1:0] cap;
    logic             hit;
    logic [VAL_W-1:0] hit_value;
    logic             tail_valid;
    logic [KEY_W-1:0] tail_key;
    t_cmd             cmd;

    t_entry           chain     [MAX_ENTRIES+1];
    logic             hit_chain [MAX_ENTRIES+1];
    logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
    logic             cell_tail  [MAX_ENTRIES];
    logic [KEY_W-1:0] cell_tkey  [MAX_ENTRIES];

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign accept      = start && !r_busy;
    assign cfg_write   = i_cfg_valid && !r_busy;

    // clamp the active entry count to 1..MAX_ENTRIES
    assign active_ext = CAP_W'(r_active);
    always_comb begin
        if (active_ext == '0) begin
            cap = CAP_W'(1);
        end else if (active_ext > CAP_W'(MAX_ENTRIES)) begin
            cap = CAP_W'(MAX_ENTRIES);
        end else begin
            cap = active_ext;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
        end else if (cfg_write) begin
            r_active <= i_cfg_data;
        end
    end

    // command stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // broadcast command and head word of the row
    assign hit = hit_chain[0];
    assign cmd = '{go: r_busy, hit: hit, set: (r_mode == MODE_SET), key: r_key};
    assign chain[0] = '{valid: 1'b1, key: r_key,
                        value: (r_mode == MODE_SET) ? r_value : hit_value};
    assign hit_chain[MAX_ENTRIES] = 1'b0;

    // cell row
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .IDX   (g),
            .CAP_W (CAP_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clear      (cfg_write),
            .i_cmd        (cmd),
            .i_cap        (cap),
            .i_up         (chain[g]),
            .o_entry      (chain[g+1]),
            .i_hit_below  (hit_chain[g+1]),
            .o_hit_below  (hit_chain[g]),
            .o_hit_value  (cell_value[g]),
            .o_tail_valid (cell_tail[g]),
            .o_tail_key   (cell_tkey[g])
        );
    end

    // collect hit value and tail entry, at most one cell drives each
    always_comb begin
        hit_value  = '0;
        tail_valid = 1'b0;
        tail_key   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_value  = hit_value | cell_value[i];
            tail_valid = tail_valid | cell_tail[i];
            tail_key   = tail_key | cell_tkey[i];
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_found       <= hit;
            r_read_value  <= (hit && (r_mode == MODE_GET)) ? hit_value : '0;
            r_evicted     <= !hit && (r_mode == MODE_SET) && tail_valid;
            r_evicted_key <= (!hit && (r_mode == MODE_SET)) ? tail_key : '0;
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

endmodule

// ----- dv/lru_key_value_cache_core_tb.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_tb: self-checking bench for the lru key/value cache
// Drives get/set words through the start/busy channel and rewrites the
// capacity register between phases. A shadow cache in the bench predicts
// found, read value and eviction for every accepted word. Each strobed result
// is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int SLOTS       = MAX_ENTRIES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 155;
    localparam int PEND_DEPTH  = 8;
    localparam int POOL_MAX    = 2 * SLOTS + 1;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_ONES = {VAL_W{1'b1}};

    // expected outcome of one cache operation
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } t_lookup_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_mode;
    logic [KEY_W-1:0] i_key;
    logic [VAL_W-1:0] i_value;
    logic             o_done;
    logic             o_found;
    logic [VAL_W-1:0] o_read_value;
    logic             o_evicted;
    logic [KEY_W-1:0] o_evicted_key;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // shadow copy of the cache contents
    logic             shadow_used [SLOTS];
    logic [KEY_W-1:0] shadow_key  [SLOTS];
    logic [VAL_W-1:0] shadow_val  [SLOTS];
    logic [3:0]       shadow_age  [SLOTS];
    int unsigned      shadow_fill;
    logic [CFG_W-1:0] shadow_cap;

    // ring of expected results, oldest at the read index
    t_lookup_result   pending_buf [PEND_DEPTH];
    int               pend_wr;
    int               pend_rd;
    int               error_count;
    int               words_sent;
    int               results_seen;
    int               hit_count;
    int               evict_count;
    int               cap_writes;

    lru_key_value_cache_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // number of results still expected
    function automatic int pending_count();
        return pend_wr - pend_rd;
    endfunction

    // capacity as the cache applies it
    function automatic int unsigned usable_slots(input logic [CFG_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > SLOTS)
            return SLOTS;
        return cap;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_age[i]  = '0;
        end
        shadow_fill = 0;
    endfunction

    // apply one word to the shadow cache and return what the cache must report
    function automatic t_lookup_result predict_lookup(input logic mode,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [VAL_W-1:0] value);
        t_lookup_result res;
        int             hit;
        int             slot;
        logic [3:0]     old_age;
        logic [3:0]     worst;
        res  = '0;
        hit  = -1;
        slot = -1;
        worst = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && shadow_used[i] && shadow_key[i] == key)
                hit = i;
        end
        if (hit >= 0) begin
            // hit: read or overwrite, then move to the front
            res.found = 1'b1;
            if (mode == MODE_GET)
                res.read_value = shadow_val[hit];
            else
                shadow_val[hit] = value;
            old_age = shadow_age[hit];
            for (int i = 0; i < SLOTS; i++) begin
                if (shadow_used[i] && i != hit && shadow_age[i] < old_age)
                    shadow_age[i]++;
            end
            shadow_age[hit] = '0;
        end else if (mode == MODE_SET) begin
            // miss on set: drop the oldest entry when full
            if (shadow_fill >= usable_slots(shadow_cap)) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_used[i] && (slot < 0 || shadow_age[i] > worst)) begin
                        slot  = i;
                        worst = shadow_age[i];
                    end
                end
                if (slot >= 0) begin
                    res.evicted     = 1'b1;
                    res.evicted_key = shadow_key[slot];
                    shadow_used[slot] = 1'b0;
                    shadow_fill--;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot < 0 && !shadow_used[i])
                        slot = i;
                end
            end
            if (slot >= 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_used[i])
                        shadow_age[i]++;
                end
                shadow_used[slot] = 1'b1;
                shadow_key[slot]  = key;
                shadow_val[slot]  = value;
                shadow_age[slot]  = '0;
                shadow_fill++;
            end
        end
        return res;
    endfunction

    // send one word and record its expected result once taken
    task automatic send_word(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        t_lookup_result res;
        @(negedge i_clk);
        start   <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        i_value <= value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        res = predict_lookup(mode, key, value);
        pending_buf[pend_wr % PEND_DEPTH] = res;
        pend_wr++;
        words_sent++;
        if (res.found)
            hit_count++;
        if (res.evicted)
            evict_count++;
    endtask

    // sender gap, start held low between words
    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge i_clk);
    endtask

    // hold off until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count() != 0)
            @(posedge i_clk);
    endtask

    // capacity write, only with the cache idle
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        drain_results();
        repeat (3)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        shadow_cap = cap;
        clear_shadow();
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp, act);
            error_count++;
        end
    endtask

    // compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_result exp;
        if (i_rst_n && o_done === 1'b1) begin
            results_seen++;
            if (pending_count() == 0) begin
                $display("%0t: result with nothing expected, expected none actual found=%b",
                         $time, o_found);
                error_count++;
            end else begin
                exp = pending_buf[pend_rd % PEND_DEPTH];
                pend_rd++;
                check_field("found", exp.found, o_found);
                check_field("read_value", exp.read_value, o_read_value);
                check_field("evicted", exp.evicted, o_evicted);
                check_field("evicted_key", exp.evicted_key, o_evicted_key);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_done === 1'b1 ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("lru_key_value_cache_core_tb: errors");
        $finish;
    end

    // boundary keys and values at the reset capacity
    task automatic test_get_set_extremes();
        send_word(MODE_GET, '0, '0);
        send_word(MODE_SET, '0, VAL_ONES);
        send_word(MODE_GET, '0, '0);
        send_word(MODE_SET, KEY_ONES, '0);
        send_word(MODE_SET, KEY_ONES, 31'h2AAA_AAAA);
        send_word(MODE_GET, KEY_ONES, '0);
        send_word(MODE_GET, 32'h5555_5555, '0);
        send_word(MODE_GET, '0, VAL_ONES);
    endtask

    // two slots: a get refreshes an entry so the other one is dropped
    task automatic test_lru_order();
        write_capacity(5'd2);
        send_word(MODE_SET, 32'hA5A5_0001, 31'h0000_0011);
        send_word(MODE_SET, 32'hA5A5_0002, 31'h0000_0022);
        send_word(MODE_GET, 32'hA5A5_0001, '0);
        send_word(MODE_SET, 32'hA5A5_0003, 31'h0000_0033);
        send_word(MODE_GET, 32'hA5A5_0002, '0);
        send_word(MODE_GET, 32'hA5A5_0001, '0);
        send_word(MODE_GET, 32'hA5A5_0003, '0);
    endtask

    // capacity zero behaves as a single slot
    task automatic test_min_capacity();
        write_capacity(5'd0);
        send_word(MODE_SET, 32'h0F0F_1234, 31'h1234_5678);
        send_word(MODE_SET, 32'hF0F0_4321, 31'h0765_4321);
        send_word(MODE_GET, 32'h0F0F_1234, '0);
        send_word(MODE_SET, 32'hF0F0_4321, 31'h7FFF_0000);
    endtask

    // random gets and sets over a small key pool per capacity setting
    task automatic test_random_traffic(input int idle_pct, input logic [CFG_W-1:0] cap_a,
                                       input logic [CFG_W-1:0] cap_b,
                                       input logic [CFG_W-1:0] cap_c,
                                       input logic [CFG_W-1:0] cap_d);
        logic [CFG_W-1:0] caps [4];
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             mode;
        int               pool_size;
        int               pick;
        caps[0] = cap_a;
        caps[1] = cap_b;
        caps[2] = cap_c;
        caps[3] = cap_d;
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            // a pool a bit larger than the capacity gives hits and evictions
            pool_size = usable_slots(caps[p]) + 1 +
                        $urandom_range(0, usable_slots(caps[p]));
            for (int k = 0; k < pool_size; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    key_pool[k] = '0;
                else if (pick == 1)
                    key_pool[k] = KEY_ONES;
                else
                    key_pool[k] = $urandom();
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2)
                    drain_results();
                if ($urandom_range(0, 99) < idle_pct)
                    idle_cycles($urandom_range(1, 4));
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = VAL_ONES;
                else
                    value = $urandom();
                if ($urandom_range(0, 9) == 0) begin
                    // noise: unrelated key, almost always a miss
                    key  = $urandom();
                    mode = $urandom_range(0, 1);
                end else begin
                    key  = key_pool[$urandom_range(0, pool_size - 1)];
                    mode = ($urandom_range(0, 99) < 45) ? MODE_SET : MODE_GET;
                end
                send_word(mode, key, value);
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_GET;
        i_key        = '0;
        i_value      = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        pend_wr      = 0;
        pend_rd      = 0;
        error_count  = 0;
        words_sent   = 0;
        results_seen = 0;
        hit_count    = 0;
        evict_count  = 0;
        cap_writes   = 0;
        shadow_cap   = ACTIVE_RST;
        clear_shadow();
        repeat (7)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_get_set_extremes();
        test_lru_order();
        test_min_capacity();
        test_random_traffic(15, 5'd4, 5'd16, 5'd1, 5'd9);
        test_random_traffic(76, 5'd31, 5'd0, 5'd6, 5'd12);
        test_random_traffic(0, 5'd17, 5'd2, 5'd16, 5'd8);

        drain_results();
        repeat (8)
            @(posedge i_clk);

        $display("run covered %0d words (%0d hits, %0d evictions), %0d results checked,",
                 words_sent, hit_count, evict_count, results_seen);
        $display("capacity rewritten %0d times from 0 up to 31", cap_writes);
        if (error_count == 0 && pending_count() == 0) begin
            $display("lru_key_value_cache_core_tb: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, pending_count());
            $display("lru_key_value_cache_core_tb: errors");
        end
        $finish;
    end

endmodule
